// ----- hw/rtl/bfs_pkg.sv -----
`timescale 1ns / 1ps

package bfs_pkg;

   // Fixed field widths
   localparam int VERT_W = 7;
   localparam int EDGE_W = 2 * VERT_W;

   // Defaults for the top-level parameters
   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_EDGES_DEF    = 1024;

   // Configuration register map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_VERTICES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_VERTEX = 1'b1;

   // Register reset values
   localparam logic [VERT_W-1:0] NUM_VERTICES_RST  = 7'd64;
   localparam logic [VERT_W-1:0] TARGET_VERTEX_RST = 7'd1;

   // Source vertex of every search
   localparam logic [VERT_W-1:0] SRC_VERTEX = 7'd1;

endpackage

// ----- hw/rtl/bfs_req_if.sv -----
`timescale 1ns / 1ps

interface bfs_req_if;
   import bfs_pkg::*;

   logic              valid;
   logic              ready;
   logic [VERT_W-1:0] end_a;
   logic [VERT_W-1:0] end_b;
   logic              last_edge;

   modport source (output valid, output end_a, output end_b, output last_edge,
                   input ready);
   modport sink   (input valid, input end_a, input end_b, input last_edge,
                   output ready);
endinterface

// ----- hw/rtl/bfs_rsp_if.sv -----
`timescale 1ns / 1ps

interface bfs_rsp_if;
   import bfs_pkg::*;

   logic              valid;
   logic              ready;
   logic [VERT_W-1:0] path_vertex;
   logic              found;
   logic              last_of_path;

   modport source (output valid, output path_vertex, output found,
                   output last_of_path, input ready);
   modport sink   (input valid, input path_vertex, input found,
                   input last_of_path, output ready);
endinterface

// ----- hw/rtl/bfs_edge_ram.sv -----
`timescale 1ns / 1ps

module bfs_edge_ram #(
   parameter int DEPTH  = bfs_pkg::MAX_EDGES_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [bfs_pkg::EDGE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [bfs_pkg::EDGE_W-1:0] rd_data
);
   import bfs_pkg::*;

   logic [EDGE_W-1:0] mem [DEPTH];
   logic [EDGE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bfs_search.sv -----
`timescale 1ns / 1ps

module bfs_search #(
   parameter int MAX_VERTICES = bfs_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = bfs_pkg::MAX_EDGES_DEF,
   parameter int ADDR_W       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [bfs_pkg::VERT_W-1:0] n_vert,
   input  logic [bfs_pkg::VERT_W-1:0] target,
   bfs_req_if.sink                    req,
   bfs_rsp_if.source                  rsp,
   output logic                       ram_wr_en,
   output logic [ADDR_W-1:0]          ram_wr_addr,
   output logic [bfs_pkg::EDGE_W-1:0] ram_wr_data,
   output logic [ADDR_W-1:0]          ram_rd_addr,
   input  logic [bfs_pkg::EDGE_W-1:0] ram_rd_data
);
   import bfs_pkg::*;

   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int QW  = $clog2(MAX_VERTICES + 1);
   localparam int QAW = $clog2(MAX_VERTICES);
   localparam int VIW = $clog2(MAX_VERTICES + 1);
   localparam logic [VERT_W-1:0] VMAX = VERT_W'(MAX_VERTICES);
   localparam logic [QW-1:0]     QMAX = QW'(MAX_VERTICES);
   localparam logic [EW-1:0]     EMAX = EW'(MAX_EDGES);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_DEQ, S_DEQW, S_SCAN, S_PSTART,
      S_PWALK, S_PWAIT, S_PRD, S_PLD, S_PSEND
   } state_type;

   state_type             state_ff, state_in;
   logic [EW-1:0]         cnt_ff, cnt_in;
   logic [EW-1:0]         idx_ff, idx_in;
   logic [QW-1:0]         head_ff, head_in;
   logic [QW-1:0]         tail_ff, tail_in;
   logic [QW-1:0]         depth_ff, depth_in;
   logic [VERT_W-1:0]     cur_ff, cur_in;
   logic [MAX_VERTICES:0] seen_ff, seen_in;
   logic                  rvalid_ff, rvalid_in;
   logic [VERT_W-1:0]     rvert_ff, rvert_in;
   logic                  rfound_ff, rfound_in;
   logic                  rlast_ff, rlast_in;

   // Work memories
   logic [VERT_W-1:0] queue_mem  [MAX_VERTICES];
   logic [VERT_W-1:0] parent_mem [MAX_VERTICES + 1];
   logic [VERT_W-1:0] stack_mem  [MAX_VERTICES];
   logic [VERT_W-1:0] q_rd_ff, p_rd_ff, s_rd_ff;

   logic              q_we, p_we, s_we;
   logic [QAW-1:0]    q_waddr;
   logic [VERT_W-1:0] q_wdata;
   logic [VIW-1:0]    p_waddr;
   logic [VERT_W-1:0] p_wdata;

   logic              accept, a_ok, b_ok;
   logic [VERT_W-1:0] ea, eb, other;
   logic              hit, other_ok, discover, t_ok;
   logic [EW-1:0]     idx_nx;
   logic [QW-1:0]     depth_dec;

   assign accept    = req.valid && req.ready;
   assign a_ok      = (req.end_a != '0) && (req.end_a <= n_vert);
   assign b_ok      = (req.end_b != '0) && (req.end_b <= n_vert);
   assign ea        = ram_rd_data[EDGE_W-1:VERT_W];
   assign eb        = ram_rd_data[VERT_W-1:0];
   assign hit       = (ea == cur_ff) || (eb == cur_ff);
   assign other     = (ea == cur_ff) ? eb : ea;
   assign other_ok  = (other != '0) && (other <= VMAX);
   assign discover  = hit && other_ok && !seen_ff[other[VIW-1:0]] && (tail_ff < QMAX);
   assign t_ok      = (target != '0) && (target <= n_vert) && (target <= VMAX)
                      && seen_ff[target[VIW-1:0]];
   assign idx_nx    = idx_ff + EW'(1);
   assign depth_dec = depth_ff - QW'(1);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      depth_in  = depth_ff;
      cur_in    = cur_ff;
      seen_in   = seen_ff;
      rvalid_in = rvalid_ff;
      rvert_in  = rvert_ff;
      rfound_in = rfound_ff;
      rlast_in  = rlast_ff;
      q_we      = 1'b0;
      q_waddr   = tail_ff[QAW-1:0];
      q_wdata   = other;
      p_we      = 1'b0;
      p_waddr   = other[VIW-1:0];
      p_wdata   = cur_ff;
      s_we      = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_ff[ADDR_W-1:0];
      ram_wr_data = {req.end_a, req.end_b};
      ram_rd_addr = (state_ff == S_SCAN) ? idx_nx[ADDR_W-1:0] : '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (a_ok && b_ok && (cnt_ff < EMAX)) begin
                  ram_wr_en = 1'b1;
                  cnt_in    = cnt_ff + EW'(1);
               end
               if (req.last_edge) begin
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            seen_in    = '0;
            seen_in[1] = 1'b1;
            p_we       = 1'b1;
            p_waddr    = SRC_VERTEX[VIW-1:0];
            p_wdata    = '0;
            q_we       = 1'b1;
            q_waddr    = '0;
            q_wdata    = SRC_VERTEX;
            head_in    = '0;
            tail_in    = QW'(1);
            state_in   = S_DEQ;
         end
         S_DEQ: begin
            state_in = (head_ff == tail_ff) ? S_PSTART : S_DEQW;
         end
         S_DEQW: begin
            cur_in   = q_rd_ff;
            head_in  = head_ff + QW'(1);
            idx_in   = '0;
            state_in = (cnt_ff == '0) ? S_DEQ : S_SCAN;
         end
         S_SCAN: begin
            if (discover) begin
               seen_in[other[VIW-1:0]] = 1'b1;
               p_we    = 1'b1;
               q_we    = 1'b1;
               tail_in = tail_ff + QW'(1);
            end
            if (idx_nx < cnt_ff) begin
               idx_in = idx_nx;
            end else begin
               state_in = S_DEQ;
            end
         end
         S_PSTART: begin
            cnt_in = '0;
            if (t_ok) begin
               cur_in   = target;
               depth_in = '0;
               state_in = S_PWALK;
            end else begin
               rvert_in  = '0;
               rfound_in = 1'b0;
               rlast_in  = 1'b1;
               rvalid_in = 1'b1;
               state_in  = S_PSEND;
            end
         end
         S_PWALK: begin
            s_we     = 1'b1;
            depth_in = depth_ff + QW'(1);
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            cur_in   = p_rd_ff;
            state_in = ((p_rd_ff == '0) || (depth_ff == QMAX)) ? S_PRD : S_PWALK;
         end
         S_PRD: begin
            state_in = S_PLD;
         end
         S_PLD: begin
            rvert_in  = s_rd_ff;
            rfound_in = 1'b1;
            rlast_in  = (depth_ff == QW'(1));
            rvalid_in = 1'b1;
            depth_in  = depth_dec;
            state_in  = S_PSEND;
         end
         S_PSEND: begin
            if (rsp.ready) begin
               rvalid_in = 1'b0;
               state_in  = rlast_ff ? S_IDLE : S_PRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         seen_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         seen_ff   <= seen_in;
         rvalid_ff <= rvalid_in;
      end
      idx_ff    <= idx_in;
      depth_ff  <= depth_in;
      cur_ff    <= cur_in;
      rvert_ff  <= rvert_in;
      rfound_ff <= rfound_in;
      rlast_ff  <= rlast_in;
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      q_rd_ff <= queue_mem[head_ff[QAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         parent_mem[p_waddr] <= p_wdata;
      end
      p_rd_ff <= parent_mem[cur_ff[VIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         stack_mem[depth_ff[QAW-1:0]] <= cur_ff;
      end
      s_rd_ff <= stack_mem[depth_dec[QAW-1:0]];
   end

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rvalid_ff;
   assign rsp.path_vertex  = rvert_ff;
   assign rsp.found        = rfound_ff;
   assign rsp.last_of_path = rlast_ff;

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= tail_ff) && (tail_ff <= QMAX))
      else $error("queue head passed tail or tail overflowed");

   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= EMAX)
      else $error("edge count beyond store depth");

   a_miss_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.found) |-> rsp.last_of_path)
      else $error("unreachable result not flagged last");

   a_src_seen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> seen_ff[1])
      else $error("source vertex not marked during scan");

   a_cnt_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last_of_path) |=> (cnt_ff == '0))
      else $error("edge list not emptied after run");

endmodule

// ----- hw/rtl/bfs_shortest_path_core.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Handshake    Payload
// req_if   in   valid/ready  end_a[6:0], end_b[6:0], last_edge
// rsp_if   out  valid/ready  path_vertex[6:0], found, last_of_path
// csr_*    in   csr_wr_en    csr_index[0], csr_wr_data[6:0]
//
// An edge item without last_edge is taken and ready stays high, so edges
// may follow back to back.
// A last item runs the search: a set-up step, then for each dequeued vertex a
// dequeue step and a scan of every stored edge (one edge RAM read a cycle), a step
// to close the search, then a walk of the parent store from the target back and an
// unstack of the path that gives the results one at a time.
// req_if.ready is low from the last item until the final result is taken.
// Results wait in an output register while rsp_if.ready is low.
// Synchronous active-high reset; no clearing pass, the edge store needs none.

module bfs_shortest_path_core #(
   parameter int MAX_VERTICES = bfs_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = bfs_pkg::MAX_EDGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   bfs_req_if.sink                       req_if,
   bfs_rsp_if.source                     rsp_if,
   input  logic                          csr_wr_en,
   input  logic [bfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfs_pkg::VERT_W-1:0]    csr_wr_data
);
   import bfs_pkg::*;

   localparam int ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam logic [VERT_W-1:0] VMAX = VERT_W'(MAX_VERTICES);

   logic [VERT_W-1:0] num_ff, num_in;
   logic [VERT_W-1:0] target_ff, target_in;
   logic [VERT_W-1:0] n_vert;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [EDGE_W-1:0] ram_wr_data, ram_rd_data;

   // register writes
   always_comb begin
      num_in    = num_ff;
      target_in = target_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_VERTICES:  num_in    = csr_wr_data;
            CSR_TARGET_VERTEX: target_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff    <= NUM_VERTICES_RST;
         target_ff <= TARGET_VERTEX_RST;
      end else begin
         num_ff    <= num_in;
         target_ff <= target_in;
      end
   end

   // vertex count clamped to 1..MAX_VERTICES
   assign n_vert = (num_ff == '0) ? VERT_W'(1) : ((num_ff > VMAX) ? VMAX : num_ff);

   bfs_edge_ram #(
      .DEPTH  (MAX_EDGES),
      .ADDR_W (ADDR_W)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bfs_search #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .ADDR_W       (ADDR_W)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .n_vert      (n_vert),
      .target      (target_ff),
      .req         (req_if),
      .rsp         (rsp_if),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule
